// ----- hw/rtl/sfgr_pkg.sv -----
package sfgr_pkg;

  // Field widths fixed by the channel formats
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned SCALE_W     = 8;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Default coordinate wrap width
  localparam int unsigned COORD_BITS_DEF = 16;

  // Font geometry
  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;
  localparam logic [CODE_W-1:0] LAST_CODE  = 8'd126;
  localparam int unsigned GLYPH_COLS   = 5;
  localparam int unsigned GLYPH_ROWS   = 8;
  localparam int unsigned GLYPH_BITS   = GLYPH_COLS * GLYPH_ROWS;
  localparam int unsigned GLYPH_COUNT  = 95;
  localparam int unsigned GLYPH_IDX_W  = 7;
  localparam int unsigned COL_W        = 3;
  localparam int unsigned ROW_W        = 3;
  localparam logic [COL_W-1:0] LAST_COL = 3'd4;
  localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd2;

  // Configuration reset values
  localparam logic [COLOR_W-1:0] FG_RESET    = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 16'h0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;

  typedef struct packed {
    logic              start_string;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [CODE_W-1:0]  char_code;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] rect_x0;
    logic [COORD_W-1:0] rect_y0;
    logic [COORD_W-1:0] rect_x1;
    logic [COORD_W-1:0] rect_y1;
    logic [COLOR_W-1:0] fill_color;
    logic               is_foreground;
    logic               last_rect;
  } out_word_t;

  // Launch command from the front end to the glyph walker
  typedef struct packed {
    logic                  start;
    logic                  opaque;
    logic [GLYPH_BITS-1:0] glyph;
  } walk_cmd_t;

  // Glyph bits: bit col*8+row, rows LSB first inside each column
  localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h122a7f2a24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221c00, 40'h001c224100, 40'h14083e0814, 40'h08083e0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3e4549513e, 40'h00407f4200, 40'h4649516142, 40'h314b454121,
    40'h107f121418, 40'h3945454527, 40'h3049494a3c, 40'h0305097101,
    40'h3649494936, 40'h1e29494906, 40'h0000363600, 40'h0000365600,
    40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
    40'h3e41794932, 40'h7e1111117e, 40'h364949497f, 40'h224141413e,
    40'h1c2241417f, 40'h414949497f, 40'h010909097f, 40'h7a4949413e,
    40'h7f0808087f, 40'h00417f4100, 40'h013f414020, 40'h412214087f,
    40'h404040407f, 40'h7f020c027f, 40'h7f1008047f, 40'h3e4141413e,
    40'h060909097f, 40'h5e2151413e, 40'h462919097f, 40'h3149494946,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417f00,
    40'h2010080402, 40'h007f414100, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487f, 40'h2044444438,
    40'h7f48444438, 40'h1854545438, 40'h0201097e08, 40'h3e5252520c,
    40'h780404087f, 40'h00407d4400, 40'h003d444020, 40'h004428107f,
    40'h00407f4100, 40'h780418047c, 40'h780404087c, 40'h3844444438,
    40'h081414147c, 40'h7c18141408, 40'h080404087c, 40'h2054545448,
    40'h2040443f04, 40'h7c2040403c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h3c5050500c, 40'h444c546444, 40'h0041360800,
    40'h0000000000, 40'h0000000000, 40'h0000000000
  };

  function automatic logic code_in_font(input logic [CODE_W-1:0] code);
    code_in_font = (code >= FIRST_CODE) && (code <= LAST_CODE);
  endfunction

  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offs;
    offs = code - FIRST_CODE;
    if (code_in_font(code)) begin
      glyph_bits = GLYPH_ROM[offs[GLYPH_IDX_W-1:0]];
    end else begin
      glyph_bits = '0;
    end
  endfunction

endpackage

// ----- hw/rtl/sfgr_stream_if.sv -----
interface sfgr_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sfgr_walker.sv -----
module sfgr_walker #(
  parameter int unsigned COORD_BITS = sfgr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfgr_pkg::walk_cmd_t            cmd,
  input  logic [COORD_BITS-1:0]          base_col,
  input  logic [COORD_BITS-1:0]          base_row,
  input  logic [sfgr_pkg::COLOR_W-1:0]   fg_color,
  input  logic [sfgr_pkg::COLOR_W-1:0]   bg_color,
  input  logic [sfgr_pkg::SCALE_W-1:0]   scale,
  output logic                           walk_ready,
  sfgr_stream_if.source                  out_ch
);

  logic                            busy_r, busy_nxt;
  logic                            opaque_r, opaque_nxt;
  logic [sfgr_pkg::GLYPH_BITS-1:0] glyph_r, glyph_nxt;
  logic [sfgr_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [sfgr_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [COORD_BITS-1:0]           x_r, x_nxt;
  logic [COORD_BITS-1:0]           y_r, y_nxt;
  logic [COORD_BITS-1:0]           row0_r, row0_nxt;
  logic                            ovalid_r, ovalid_nxt;
  sfgr_pkg::out_word_t             oword_r, oword_nxt;

  logic [COORD_BITS-1:0] scale_ext;
  logic [COORD_BITS-1:0] scale_m1;
  logic                  advance;
  logic                  dot;
  logic                  emit;
  logic                  at_end;
  logic                  more_after;

  assign scale_ext = COORD_BITS'(scale);
  assign scale_m1  = scale_ext - COORD_BITS'(1);

  // Step only when the output register is free or being drained
  assign advance    = !ovalid_r || out_ch.ready;
  assign dot        = glyph_r[0];
  assign emit       = dot || opaque_r;
  assign at_end     = (col_r == sfgr_pkg::LAST_COL) && (row_r == sfgr_pkg::LAST_ROW);
  assign more_after = opaque_r ? !at_end : (glyph_r[sfgr_pkg::GLYPH_BITS-1:1] != '0);

  assign walk_ready   = !busy_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = oword_r;

  // Walk one glyph dot per step, column by column
  always_comb begin
    busy_nxt   = busy_r;
    opaque_nxt = opaque_r;
    glyph_nxt  = glyph_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    row0_nxt   = row0_r;
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    if (!busy_r) begin
      if (cmd.start) begin
        busy_nxt   = 1'b1;
        opaque_nxt = cmd.opaque;
        glyph_nxt  = cmd.glyph;
        col_nxt    = '0;
        row_nxt    = '0;
        x_nxt      = base_col;
        y_nxt      = base_row;
        row0_nxt   = base_row;
      end
    end else if (advance) begin
      // Load the output word for an emitted dot (a set dot, or any dot when opaque)
      if (emit) begin
        ovalid_nxt              = 1'b1;
        oword_nxt.rect_x0       = sfgr_pkg::COORD_W'(x_r);
        oword_nxt.rect_y0       = sfgr_pkg::COORD_W'(y_r);
        oword_nxt.rect_x1       = sfgr_pkg::COORD_W'(COORD_BITS'(x_r + scale_m1));
        oword_nxt.rect_y1       = sfgr_pkg::COORD_W'(COORD_BITS'(y_r + scale_m1));
        oword_nxt.fill_color    = dot ? fg_color : bg_color;
        oword_nxt.is_foreground = dot;
        oword_nxt.last_rect     = !more_after;
      end
      glyph_nxt = glyph_r >> 1;
      if (row_r == sfgr_pkg::LAST_ROW) begin
        row_nxt = '0;
        y_nxt   = row0_r;
        col_nxt = col_r + sfgr_pkg::COL_W'(1);
        x_nxt   = x_r + scale_ext;
        if (col_r == sfgr_pkg::LAST_COL) begin
          busy_nxt = 1'b0;
        end
      end else begin
        row_nxt = row_r + sfgr_pkg::ROW_W'(1);
        y_nxt   = y_r + scale_ext;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Datapath state
  always_ff @(posedge clk) begin
    opaque_r <= opaque_nxt;
    glyph_r  <= glyph_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    row0_r   <= row0_nxt;
    oword_r  <= oword_nxt;
  end

endmodule

// ----- hw/rtl/scaled_font_glyph_rasterizer_core.sv -----
// Channel   Dir  Word                                          Handshake
// in_ch     in   start_string, x_start, y_start, char_code     valid/ready
// out_ch    out  rect_x0/y0/x1/y1, fill_color, is_fg, last     valid/ready
// cfg_*     in   cfg_idx, cfg_wdata                             cfg_we, no wait
//
// A character loads the walker, then walks one glyph dot per cycle, out_ch permitting,
// through the 5x8 font columns; a dot that draws nothing still uses its step.
// A code outside the font starts no walk. in_ch is not ready while a glyph walks.
// A stall on out_ch freezes the walk; the output register holds the waiting word.
// rst_n is synchronous; it restores the default colors, scale 1 and cursor 0,0.
module scaled_font_glyph_rasterizer_core #(
  parameter int unsigned COORD_BITS = sfgr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfgr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sfgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sfgr_stream_if.sink                     in_ch,
  sfgr_stream_if.source                   out_ch
);

  logic [sfgr_pkg::COLOR_W-1:0] fg_r, fg_nxt;
  logic [sfgr_pkg::COLOR_W-1:0] bg_r, bg_nxt;
  logic [sfgr_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [COORD_BITS-1:0]        cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0]        cur_row_r, cur_row_nxt;

  sfgr_pkg::in_word_t    in_word;
  sfgr_pkg::walk_cmd_t   cmd;
  logic                  walk_ready;
  logic                  in_fire;
  logic [COORD_BITS-1:0] base_col;
  logic [COORD_BITS-1:0] base_row;
  logic [COORD_BITS-1:0] scale_ext;
  logic [COORD_BITS-1:0] adv_step;

  assign in_word     = in_ch.data;
  assign in_ch.ready = walk_ready;
  assign in_fire     = in_ch.valid && walk_ready;

  // Pick the cursor origin for this word
  assign base_col  = in_word.start_string ? in_word.x_start[COORD_BITS-1:0] : cur_col_r;
  assign base_row  = in_word.start_string ? in_word.y_start[COORD_BITS-1:0] : cur_row_r;
  assign scale_ext = COORD_BITS'(scale_r);
  assign adv_step  = (scale_ext << 2) + (scale_ext << 1);

  assign cmd.start  = in_fire && sfgr_pkg::code_in_font(in_word.char_code);
  assign cmd.opaque = (fg_r != bg_r);
  assign cmd.glyph  = sfgr_pkg::glyph_bits(in_word.char_code);

  // Configuration writes
  always_comb begin
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    scale_nxt = scale_r;
    if (cfg_we) begin
      case (cfg_idx)
        sfgr_pkg::REG_FG_COLOR: fg_nxt    = cfg_wdata[sfgr_pkg::COLOR_W-1:0];
        sfgr_pkg::REG_BG_COLOR: bg_nxt    = cfg_wdata[sfgr_pkg::COLOR_W-1:0];
        sfgr_pkg::REG_SCALE:    scale_nxt = cfg_wdata[sfgr_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the cursor by six dots on every accepted word
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (in_fire) begin
      cur_col_nxt = base_col + adv_step;
      cur_row_nxt = base_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r      <= sfgr_pkg::FG_RESET;
      bg_r      <= sfgr_pkg::BG_RESET;
      scale_r   <= sfgr_pkg::SCALE_RESET;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
      scale_r   <= scale_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  sfgr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .base_col   (base_col),
    .base_row   (base_row),
    .fg_color   (fg_r),
    .bg_color   (bg_r),
    .scale      (scale_r),
    .walk_ready (walk_ready),
    .out_ch     (out_ch)
  );

endmodule
